// File: rtl/lstm_cell_update_macros.svh
// ----------------------------------------------------------------------------
// LSTM cell update assertion macros
// Concurrent assertion shorthands clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LSTM_CELL_UPDATE_MACROS_SVH
`define LSTM_CELL_UPDATE_MACROS_SVH

// Condition holds at every edge.
`define LCU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies the consequent, non-overlapping (|=>).
`define LCU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lcu_pkg.sv
// ----------------------------------------------------------------------------
// LSTM cell update package
// Number format, sigmoid node table and the fixed-point helper functions.
// ----------------------------------------------------------------------------
package lcu_pkg;

    localparam int DATA_WIDTH     = 16;
    localparam int FRAC_BITS      = 12;
    localparam int TABLE_SEGMENTS = 32;

    localparam int SEG_BITS  = $clog2(TABLE_SEGMENTS);
    localparam int SPAN_BITS = FRAC_BITS + 4;
    localparam int STEP_BITS = SPAN_BITS - SEG_BITS;
    localparam int ACT_FRAC  = 30;
    localparam int NODE_W    = ACT_FRAC + 1;
    localparam int TANH_W    = NODE_W + 1;
    localparam int ARG_W     = DATA_WIDTH + 1;
    localparam int PROD_W    = NODE_W + STEP_BITS;
    localparam int CAND_W    = FRAC_BITS + 2;
    localparam int ACC_W     = NODE_W + DATA_WIDTH + 1;
    localparam int PEEP_W    = 2 * DATA_WIDTH;
    localparam int WIDE_W    = 64;

    localparam longint ONE_Q30    = longint'(1) <<< ACT_FRAC;
    localparam longint DATA_MAX   = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    localparam longint DATA_MIN   = -(longint'(1) <<< (DATA_WIDTH - 1));
    localparam int     SIG_OFFSET = 1 << (FRAC_BITS + 3);
    localparam int     SIG_SPAN   = 1 << SPAN_BITS;
    localparam int     CAND_MAX   = 1 << FRAC_BITS;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [TABLE_SEGMENTS:0][NODE_W-1:0] node_tab_t;

    typedef struct packed {
        logic [NODE_W-1:0]    base;
        logic [NODE_W-1:0]    diff;
        logic [STEP_BITS-1:0] frac;
    } seg_t;

    // restoring quotient of two non-negative values, table build only
    function automatic longint const_div(longint num, longint den);
        logic [WIDE_W-1:0] q;
        logic [WIDE_W:0]   r;
        int                i;
        q = '0;
        r = '0;
        for (i = WIDE_W - 1; i >= 0; i--)
        begin
            r = {r[WIDE_W-1:0], num[i]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return longint'(q);
    endfunction

    // sigmoid nodes over [-8, 8] in Q30; exp series squared four times
    function automatic node_tab_t build_sig_nodes();
        node_tab_t tab;
        longint    d;
        longint    u;
        longint    term;
        longint    sum;
        longint    den;
        longint    pos;
        int        k;
        int        n;
        int        s;
        tab = '0;
        for (k = 0; k <= TABLE_SEGMENTS; k++)
        begin
            d = longint'(TABLE_SEGMENTS) - 2 * longint'(k);
            if (d < 0)
            begin
                d = -d;
            end
            u    = (d <<< ACT_FRAC) / (2 * TABLE_SEGMENTS);
            term = ONE_Q30;
            sum  = ONE_Q30;
            for (n = 1; n <= 16; n++)
            begin
                term = const_div((term * u) >>> ACT_FRAC, longint'(n));
                if (n % 2 == 1)
                begin
                    sum = sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            for (s = 0; s < 4; s++)
            begin
                sum = (sum * sum + (ONE_Q30 >>> 1)) >>> ACT_FRAC;
            end
            den = ONE_Q30 + sum;
            pos = const_div((longint'(1) <<< (2 * ACT_FRAC)) + den / 2, den);
            tab[k] = NODE_W'((2 * k >= TABLE_SEGMENTS) ? pos : ONE_Q30 - pos);
        end
        return tab;
    endfunction

    localparam node_tab_t SIG_NODE = build_sig_nodes();

    // round to nearest, ties away from zero
    function automatic logic signed [WIDE_W-1:0] rnd_shift(logic signed [WIDE_W-1:0] x,
                                                           int unsigned n);
        logic signed [WIDE_W-1:0] half;
        half = WIDE_W'(64'sd1 <<< (n - 1));
        return (x + half - (x[WIDE_W-1] ? 64'sd1 : 64'sd0)) >>> n;
    endfunction

    function automatic data_t sat_data(logic signed [WIDE_W-1:0] x);
        data_t r;
        if (x > DATA_MAX)
        begin
            r = data_t'(DATA_MAX);
        end
        else if (x < DATA_MIN)
        begin
            r = data_t'(DATA_MIN);
        end
        else
        begin
            r = data_t'(x);
        end
        return r;
    endfunction

    function automatic data_t peep_add(data_t pre, logic signed [PEEP_W-1:0] prod);
        return sat_data(WIDE_W'(pre) + WIDE_W'(sat_data(rnd_shift(WIDE_W'(prod), FRAC_BITS))));
    endfunction

    function automatic seg_t sig_lookup(logic signed [ARG_W-1:0] x);
        logic signed [ARG_W:0] p;
        logic [SEG_BITS:0]     k;
        seg_t                  r;
        p = (ARG_W + 1)'(x) + (ARG_W + 1)'(SIG_OFFSET);
        if (p < 0)
        begin
            p = '0;
        end
        else if (p > (ARG_W + 1)'(SIG_SPAN))
        begin
            p = (ARG_W + 1)'(SIG_SPAN);
        end
        k      = p[SPAN_BITS:STEP_BITS];
        r.frac = p[STEP_BITS-1:0];
        r.base = SIG_NODE[k];
        if (k == (SEG_BITS + 1)'(TABLE_SEGMENTS))
        begin
            r.diff = '0;
        end
        else
        begin
            r.diff = SIG_NODE[k + 1'b1] - SIG_NODE[k];
        end
        return r;
    endfunction

    function automatic logic [PROD_W-1:0] interp_mul(seg_t s);
        return PROD_W'(s.diff) * PROD_W'(s.frac);
    endfunction

    function automatic logic [NODE_W-1:0] sig_finish(seg_t s, logic [PROD_W-1:0] x);
        return NODE_W'(PROD_W'(s.base) + (x >> STEP_BITS));
    endfunction

    function automatic logic signed [TANH_W-1:0] tanh_from_sig(logic [NODE_W-1:0] s);
        logic signed [TANH_W:0] t;
        t = $signed({1'b0, s, 1'b0}) - $signed((TANH_W + 1)'(ONE_Q30));
        return $signed(t[TANH_W-1:0]);
    endfunction

endpackage

// File: rtl/lcu_in_if.sv
// ----------------------------------------------------------------------------
// LSTM cell update input channel
// Valid/ready channel carrying gate pre-activations, state and peephole weights.
// ----------------------------------------------------------------------------
interface lcu_in_if;

    logic            valid;
    logic            ready;
    logic            active;
    lcu_pkg::data_t  gate_input_pre;
    lcu_pkg::data_t  gate_output_pre;
    lcu_pkg::data_t  gate_forget_pre;
    lcu_pkg::data_t  gate_cand_pre;
    lcu_pkg::data_t  cell_prev;
    lcu_pkg::data_t  hidden_prev;
    lcu_pkg::data_t  peep_input;
    lcu_pkg::data_t  peep_output;
    lcu_pkg::data_t  peep_forget;

    modport source (
        output valid, active, gate_input_pre, gate_output_pre, gate_forget_pre,
               gate_cand_pre, cell_prev, hidden_prev, peep_input, peep_output,
               peep_forget,
        input  ready
    );

    modport sink (
        input  valid, active, gate_input_pre, gate_output_pre, gate_forget_pre,
               gate_cand_pre, cell_prev, hidden_prev, peep_input, peep_output,
               peep_forget,
        output ready
    );

endinterface

// File: rtl/lcu_out_if.sv
// ----------------------------------------------------------------------------
// LSTM cell update output channel
// Valid/ready channel carrying the new cell and hidden values.
// ----------------------------------------------------------------------------
interface lcu_out_if;

    logic            valid;
    logic            ready;
    lcu_pkg::data_t  cell_new;
    lcu_pkg::data_t  hidden_new;

    modport source (
        output valid, cell_new, hidden_new,
        input  ready
    );

    modport sink (
        input  valid, cell_new, hidden_new,
        output ready
    );

endinterface

// File: rtl/lstm_cell_update.sv
// ----------------------------------------------------------------------------
// LSTM cell update
// Elementwise peephole LSTM cell for one hidden unit, signed Q3.12, saturating.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless the output stalls, and returns one beat per
// input beat, in order. The depth is set by the dependent chain through
// the cell value: peephole add, gate sigmoids, cell multiply-add, output
// peephole, output sigmoid and tanh of the new cell, then the final multiply,
// each table lookup, interpolation multiply and wide product in its own stage.
// The whole pipeline advances together whenever the last stage is empty or
// its beat is taken, so a stalled output holds every stage in place. Sigmoid
// and tanh come from one constant node table; no initialization after reset.
// The user must write peephole_enable through cfg_wr_en/cfg_wr_data only while idle (not enforced).
module lstm_cell_update (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    lcu_in_if.sink       in_ch,
    lcu_out_if.source    out_ch
);

    localparam int ST_PEEP_MUL = 0;
    localparam int ST_PEEP_ADD = 1;
    localparam int ST_LOOK     = 2;
    localparam int ST_INTERP   = 3;
    localparam int ST_ACT      = 4;
    localparam int ST_CMUL     = 5;
    localparam int ST_CELL     = 6;
    localparam int ST_OLOOK    = 7;
    localparam int ST_OADD     = 8;
    localparam int ST_OSEG     = 9;
    localparam int ST_OMUL     = 10;
    localparam int ST_OACT     = 11;
    localparam int ST_HMUL     = 12;
    localparam int ST_OUT      = 13;
    localparam int NSTAGE      = 14;

    typedef struct packed {
        logic                                  active;
        lcu_pkg::data_t                        gi;
        lcu_pkg::data_t                        gf;
        lcu_pkg::data_t                        go;
        lcu_pkg::data_t                        gc;
        lcu_pkg::data_t                        cp;
        lcu_pkg::data_t                        hp;
        lcu_pkg::data_t                        po;
        logic signed [lcu_pkg::PEEP_W-1:0]     mi;
        logic signed [lcu_pkg::PEEP_W-1:0]     mf;
        lcu_pkg::seg_t                         si;
        lcu_pkg::seg_t                         sf;
        lcu_pkg::seg_t                         sg;
        logic [lcu_pkg::PROD_W-1:0]            xi;
        logic [lcu_pkg::PROD_W-1:0]            xf;
        logic [lcu_pkg::PROD_W-1:0]            xg;
        logic [lcu_pkg::NODE_W-1:0]            it;
        logic [lcu_pkg::NODE_W-1:0]            ft;
        logic signed [lcu_pkg::CAND_W-1:0]     gt;
        logic signed [lcu_pkg::ACC_W-1:0]      ac1;
        logic signed [lcu_pkg::ACC_W-1:0]      ac2;
        lcu_pkg::data_t                        cn;
        logic signed [lcu_pkg::TANH_W-1:0]     tc;
        logic [lcu_pkg::NODE_W-1:0]            ot;
        logic signed [lcu_pkg::WIDE_W-1:0]     hm;
        lcu_pkg::data_t                        hn;
    } pipe_t;

    pipe_t [NSTAGE-1:0] pipe_reg;
    pipe_t [NSTAGE-1:0] pipe_next;
    logic  [NSTAGE-1:0] valid_reg;
    logic  [NSTAGE-1:0] valid_next;
    logic               peep_en_reg;
    logic               pipe_en;

    assign pipe_en    = !valid_reg[ST_OUT] || out_ch.ready;
    assign valid_next = {valid_reg[NSTAGE-2:0], in_ch.valid};

    assign in_ch.ready       = pipe_en;
    assign out_ch.valid      = valid_reg[ST_OUT];
    assign out_ch.cell_new   = pipe_reg[ST_OUT].cn;
    assign out_ch.hidden_new = pipe_reg[ST_OUT].hn;

    always_comb
    begin
        // input capture, peephole products on previous cell
        pipe_next[ST_PEEP_MUL]        = pipe_reg[ST_PEEP_MUL];
        pipe_next[ST_PEEP_MUL].active = in_ch.active;
        pipe_next[ST_PEEP_MUL].gi     = in_ch.gate_input_pre;
        pipe_next[ST_PEEP_MUL].gf     = in_ch.gate_forget_pre;
        pipe_next[ST_PEEP_MUL].go     = in_ch.gate_output_pre;
        pipe_next[ST_PEEP_MUL].gc     = in_ch.gate_cand_pre;
        pipe_next[ST_PEEP_MUL].cp     = in_ch.cell_prev;
        pipe_next[ST_PEEP_MUL].hp     = in_ch.hidden_prev;
        pipe_next[ST_PEEP_MUL].po     = in_ch.peep_output;
        pipe_next[ST_PEEP_MUL].mi     = lcu_pkg::PEEP_W'(in_ch.peep_input)
                                        * lcu_pkg::PEEP_W'(in_ch.cell_prev);
        pipe_next[ST_PEEP_MUL].mf     = lcu_pkg::PEEP_W'(in_ch.peep_forget)
                                        * lcu_pkg::PEEP_W'(in_ch.cell_prev);

        pipe_next[ST_PEEP_ADD] = pipe_reg[ST_PEEP_MUL];
        if (peep_en_reg)
        begin
            pipe_next[ST_PEEP_ADD].gi = lcu_pkg::peep_add(pipe_reg[ST_PEEP_MUL].gi,
                                                          pipe_reg[ST_PEEP_MUL].mi);
            pipe_next[ST_PEEP_ADD].gf = lcu_pkg::peep_add(pipe_reg[ST_PEEP_MUL].gf,
                                                          pipe_reg[ST_PEEP_MUL].mf);
        end

        pipe_next[ST_LOOK]    = pipe_reg[ST_PEEP_ADD];
        pipe_next[ST_LOOK].si = lcu_pkg::sig_lookup(lcu_pkg::ARG_W'(pipe_reg[ST_PEEP_ADD].gi));
        pipe_next[ST_LOOK].sf = lcu_pkg::sig_lookup(lcu_pkg::ARG_W'(pipe_reg[ST_PEEP_ADD].gf));
        pipe_next[ST_LOOK].sg = lcu_pkg::sig_lookup($signed({pipe_reg[ST_PEEP_ADD].gc, 1'b0}));

        pipe_next[ST_INTERP]    = pipe_reg[ST_LOOK];
        pipe_next[ST_INTERP].xi = lcu_pkg::interp_mul(pipe_reg[ST_LOOK].si);
        pipe_next[ST_INTERP].xf = lcu_pkg::interp_mul(pipe_reg[ST_LOOK].sf);
        pipe_next[ST_INTERP].xg = lcu_pkg::interp_mul(pipe_reg[ST_LOOK].sg);

        pipe_next[ST_ACT]    = pipe_reg[ST_INTERP];
        pipe_next[ST_ACT].it = lcu_pkg::sig_finish(pipe_reg[ST_INTERP].si,
                                                   pipe_reg[ST_INTERP].xi);
        pipe_next[ST_ACT].ft = lcu_pkg::sig_finish(pipe_reg[ST_INTERP].sf,
                                                   pipe_reg[ST_INTERP].xf);
        pipe_next[ST_ACT].gt = lcu_pkg::CAND_W'(lcu_pkg::rnd_shift(
                                   lcu_pkg::WIDE_W'(lcu_pkg::tanh_from_sig(
                                       lcu_pkg::sig_finish(pipe_reg[ST_INTERP].sg,
                                                           pipe_reg[ST_INTERP].xg))),
                                   lcu_pkg::ACT_FRAC - lcu_pkg::FRAC_BITS));

        pipe_next[ST_CMUL]     = pipe_reg[ST_ACT];
        pipe_next[ST_CMUL].ac1 = lcu_pkg::ACC_W'($signed({1'b0, pipe_reg[ST_ACT].ft}))
                                 * lcu_pkg::ACC_W'(pipe_reg[ST_ACT].cp);
        pipe_next[ST_CMUL].ac2 = lcu_pkg::ACC_W'($signed({1'b0, pipe_reg[ST_ACT].it}))
                                 * lcu_pkg::ACC_W'(pipe_reg[ST_ACT].gt);

        pipe_next[ST_CELL]    = pipe_reg[ST_CMUL];
        pipe_next[ST_CELL].cn = lcu_pkg::sat_data(lcu_pkg::rnd_shift(
                                    lcu_pkg::WIDE_W'(pipe_reg[ST_CMUL].ac1)
                                    + lcu_pkg::WIDE_W'(pipe_reg[ST_CMUL].ac2),
                                    lcu_pkg::ACT_FRAC));

        // output peephole product and tanh of the new cell start together
        pipe_next[ST_OLOOK]    = pipe_reg[ST_CELL];
        pipe_next[ST_OLOOK].mi = lcu_pkg::PEEP_W'(pipe_reg[ST_CELL].po)
                                 * lcu_pkg::PEEP_W'(pipe_reg[ST_CELL].cn);
        pipe_next[ST_OLOOK].sg = lcu_pkg::sig_lookup($signed({pipe_reg[ST_CELL].cn, 1'b0}));

        pipe_next[ST_OADD]    = pipe_reg[ST_OLOOK];
        pipe_next[ST_OADD].xg = lcu_pkg::interp_mul(pipe_reg[ST_OLOOK].sg);
        if (peep_en_reg)
        begin
            pipe_next[ST_OADD].go = lcu_pkg::peep_add(pipe_reg[ST_OLOOK].go,
                                                      pipe_reg[ST_OLOOK].mi);
        end

        pipe_next[ST_OSEG]    = pipe_reg[ST_OADD];
        pipe_next[ST_OSEG].si = lcu_pkg::sig_lookup(lcu_pkg::ARG_W'(pipe_reg[ST_OADD].go));
        pipe_next[ST_OSEG].tc = lcu_pkg::tanh_from_sig(
                                    lcu_pkg::sig_finish(pipe_reg[ST_OADD].sg,
                                                        pipe_reg[ST_OADD].xg));

        pipe_next[ST_OMUL]    = pipe_reg[ST_OSEG];
        pipe_next[ST_OMUL].xi = lcu_pkg::interp_mul(pipe_reg[ST_OSEG].si);

        pipe_next[ST_OACT]    = pipe_reg[ST_OMUL];
        pipe_next[ST_OACT].ot = lcu_pkg::sig_finish(pipe_reg[ST_OMUL].si,
                                                    pipe_reg[ST_OMUL].xi);

        pipe_next[ST_HMUL]    = pipe_reg[ST_OACT];
        pipe_next[ST_HMUL].hm = lcu_pkg::WIDE_W'($signed({1'b0, pipe_reg[ST_OACT].ot}))
                                * lcu_pkg::WIDE_W'(pipe_reg[ST_OACT].tc);

        pipe_next[ST_OUT] = pipe_reg[ST_HMUL];
        if (pipe_reg[ST_HMUL].active)
        begin
            pipe_next[ST_OUT].hn = lcu_pkg::sat_data(lcu_pkg::rnd_shift(
                                       pipe_reg[ST_HMUL].hm,
                                       2 * lcu_pkg::ACT_FRAC - lcu_pkg::FRAC_BITS));
        end
        else
        begin
            pipe_next[ST_OUT].cn = pipe_reg[ST_HMUL].cp;
            pipe_next[ST_OUT].hn = pipe_reg[ST_HMUL].hp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (pipe_en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            pipe_reg <= pipe_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peep_en_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            peep_en_reg <= cfg_wr_data;
        end
    end

`include "lstm_cell_update_macros.svh"

    `LCU_ASSERT_NEXT(a_peep_off_pass, pipe_en && valid_reg[ST_PEEP_MUL] && !peep_en_reg && !cfg_wr_en, pipe_reg[ST_PEEP_ADD].gi == $past(pipe_reg[ST_PEEP_MUL].gi), "input gate changed with peephole disabled")
    `LCU_ASSERT_ALWAYS(a_gate_range, !valid_reg[ST_ACT] || (pipe_reg[ST_ACT].it <= lcu_pkg::ONE_Q30 && pipe_reg[ST_ACT].ft <= lcu_pkg::ONE_Q30), "gate sigmoid above one")
    `LCU_ASSERT_ALWAYS(a_cand_range, !valid_reg[ST_ACT] || (pipe_reg[ST_ACT].gt <= lcu_pkg::CAND_MAX && pipe_reg[ST_ACT].gt >= -lcu_pkg::CAND_MAX), "candidate tanh out of range")
    `LCU_ASSERT_ALWAYS(a_out_gate_range, !valid_reg[ST_OACT] || pipe_reg[ST_OACT].ot <= lcu_pkg::ONE_Q30, "output sigmoid above one")

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// LSTM cell update testbench
// Drives gate, state and peephole beats through the valid/ready channels,
// predicts each new cell and hidden value in a scoreboard with its own
// sigmoid table and fixed-point arithmetic, and compares every output beat.
// Runs directed corner beats, then random beats under three idling mixes,
// with the peephole setting toggled between phases.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     DW       = lcu_pkg::DATA_WIDTH;
    localparam int     FB       = lcu_pkg::FRAC_BITS;
    localparam int     NSEG     = lcu_pkg::TABLE_SEGMENTS;
    localparam longint Q30_ONE  = longint'(1) <<< 30;
    localparam int     RAND_PER_PHASE = 90;

    typedef lcu_pkg::data_t data_t;

    typedef struct {
        logic  active;
        data_t gate_input_pre;
        data_t gate_output_pre;
        data_t gate_forget_pre;
        data_t gate_cand_pre;
        data_t cell_prev;
        data_t hidden_prev;
        data_t peep_input;
        data_t peep_output;
        data_t peep_forget;
    } cell_beat_t;

    typedef struct {
        data_t cell_new;
        data_t hidden_new;
    } cell_result_t;

    class cell_scoreboard;
        longint       sig_node[NSEG+1];
        bit           peep_on;
        cell_result_t expected_q[$];
        int           mismatches;
        int           results_seen;
        int           active_seen;
        int           inactive_seen;
        int           peep_seen;

        function new();
            longint d;
            longint u;
            longint term;
            longint acc;
            longint den;
            longint pos;
            peep_on = 1'b0;
            for (int k = 0; k <= NSEG; k++)
            begin
                d = longint'(NSEG) - 2 * longint'(k);
                if (d < 0)
                begin
                    d = -d;
                end
                u    = (d <<< 30) / (2 * longint'(NSEG));
                term = Q30_ONE;
                acc  = Q30_ONE;
                for (int n = 1; n <= 16; n++)
                begin
                    term = ((term * u) >>> 30) / longint'(n);
                    if (n % 2 == 1)
                    begin
                        acc = acc - term;
                    end
                    else
                    begin
                        acc = acc + term;
                    end
                end
                if (acc < 0)
                begin
                    acc = 0;
                end
                repeat (4)
                begin
                    acc = (acc * acc + (longint'(1) <<< 29)) >>> 30;
                end
                den = Q30_ONE + acc;
                pos = ((longint'(1) <<< 60) + den / 2) / den;
                sig_node[k] = (2 * k >= NSEG) ? pos : Q30_ONE - pos;
            end
        endfunction

        function longint rnd(longint x, int n);
            longint half;
            half = longint'(1) <<< (n - 1);
            if (x >= 0)
            begin
                return (x + half) >>> n;
            end
            return -((-x + half) >>> n);
        endfunction

        function longint clip(longint x);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (DW - 1)) - 1;
            lo = -(longint'(1) <<< (DW - 1));
            if (x > hi)
            begin
                return hi;
            end
            if (x < lo)
            begin
                return lo;
            end
            return x;
        endfunction

        // sigmoid of a Q3.12 value, Q30 result
        function longint sigm(longint x);
            longint lo;
            longint span;
            longint p;
            longint num;
            longint k;
            longint r;
            lo   = -(longint'(1) <<< (FB + 3));
            span = longint'(1) <<< (FB + 4);
            p    = x - lo;
            if (p < 0)
            begin
                p = 0;
            end
            if (p > span)
            begin
                p = span;
            end
            num = p * NSEG;
            k   = num / span;
            r   = num - k * span;
            if (k >= NSEG)
            begin
                return sig_node[NSEG];
            end
            return sig_node[k] + ((sig_node[k+1] - sig_node[k]) * r) / span;
        endfunction

        function longint tanh_q30(longint x);
            return 2 * sigm(2 * x) - Q30_ONE;
        endfunction

        function longint peep_sum(longint pre, longint w, longint c);
            return clip(pre + clip(rnd(w * c, FB)));
        endfunction

        function void note_input(cell_beat_t b);
            longint       arg_in;
            longint       arg_out;
            longint       arg_fgt;
            longint       c_prev;
            longint       i_act;
            longint       f_act;
            longint       g_act;
            longint       o_act;
            longint       c_new;
            longint       h_new;
            cell_result_t r;
            if (!b.active)
            begin
                r.cell_new   = b.cell_prev;
                r.hidden_new = b.hidden_prev;
                inactive_seen++;
            end
            else
            begin
                active_seen++;
                arg_in  = b.gate_input_pre;
                arg_out = b.gate_output_pre;
                arg_fgt = b.gate_forget_pre;
                c_prev  = b.cell_prev;
                if (peep_on)
                begin
                    peep_seen++;
                    arg_in  = peep_sum(arg_in, b.peep_input, c_prev);
                    arg_fgt = peep_sum(arg_fgt, b.peep_forget, c_prev);
                end
                i_act = sigm(arg_in);
                f_act = sigm(arg_fgt);
                g_act = tanh_q30(b.gate_cand_pre);
                c_new = clip(rnd(f_act * c_prev + i_act * rnd(g_act, 30 - FB), 30));
                if (peep_on)
                begin
                    arg_out = peep_sum(arg_out, b.peep_output, c_new);
                end
                o_act = sigm(arg_out);
                h_new = clip(rnd(o_act * tanh_q30(c_new), 60 - FB));
                r.cell_new   = data_t'(c_new);
                r.hidden_new = data_t'(h_new);
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(data_t cell_new, data_t hidden_new);
            cell_result_t e;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected beat: cell_new=%0d hidden_new=%0d", cell_new, hidden_new);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            if (cell_new !== e.cell_new)
            begin
                $error("cell_new mismatch: expected %0d, actual %0d", e.cell_new, cell_new);
                mismatches++;
            end
            if (hidden_new !== e.hidden_new)
            begin
                $error("hidden_new mismatch: expected %0d, actual %0d",
                       e.hidden_new, hidden_new);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    int   src_idle;
    int   sink_idle;

    cell_scoreboard sb = new();

    lcu_in_if  in_ch ();
    lcu_out_if out_ch ();

    lstm_cell_update i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #3_000_000;
        $display("** lstm_cell_update: FAILED **");
        $finish;
    end

    // output side: random stalls, check on every accepted beat
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                sb.check_result(out_ch.cell_new, out_ch.hidden_new);
            end
            @(negedge clk);
            out_ch.ready = ($urandom_range(99) >= sink_idle);
        end
    end

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_beat(input cell_beat_t b);
        while ($urandom_range(99) < src_idle)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid           = 1'b1;
        in_ch.active          = b.active;
        in_ch.gate_input_pre  = b.gate_input_pre;
        in_ch.gate_output_pre = b.gate_output_pre;
        in_ch.gate_forget_pre = b.gate_forget_pre;
        in_ch.gate_cand_pre   = b.gate_cand_pre;
        in_ch.cell_prev       = b.cell_prev;
        in_ch.hidden_prev     = b.hidden_prev;
        in_ch.peep_input      = b.peep_input;
        in_ch.peep_output     = b.peep_output;
        in_ch.peep_forget     = b.peep_forget;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        sb.note_input(b);
        @(negedge clk);
    endtask

    task automatic dir_beat(input int act, input int gi, input int go, input int gf,
                            input int gc, input int cp, input int hp,
                            input int pi, input int po, input int pf);
        cell_beat_t b;
        b.active          = (act != 0);
        b.gate_input_pre  = data_t'(gi);
        b.gate_output_pre = data_t'(go);
        b.gate_forget_pre = data_t'(gf);
        b.gate_cand_pre   = data_t'(gc);
        b.cell_prev       = data_t'(cp);
        b.hidden_prev     = data_t'(hp);
        b.peep_input      = data_t'(pi);
        b.peep_output     = data_t'(po);
        b.peep_forget     = data_t'(pf);
        send_beat(b);
    endtask

    function automatic data_t rand_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30)
        begin
            return data_t'($urandom);
        end
        if (sel < 70)
        begin
            return data_t'(int'($urandom_range(16384)) - 8192);
        end
        if (sel < 85)
        begin
            case ($urandom_range(4))
                0:       return data_t'(-32768);
                1:       return data_t'(32767);
                2:       return data_t'(0);
                3:       return data_t'(4096);
                default: return data_t'(-4096);
            endcase
        end
        return data_t'(int'($urandom_range(256)) - 128);
    endfunction

    task automatic send_random();
        cell_beat_t b;
        b.active          = ($urandom_range(99) < 85);
        b.gate_input_pre  = rand_value();
        b.gate_output_pre = rand_value();
        b.gate_forget_pre = rand_value();
        b.gate_cand_pre   = rand_value();
        b.cell_prev       = rand_value();
        b.hidden_prev     = rand_value();
        b.peep_input      = rand_value();
        b.peep_output     = rand_value();
        b.peep_forget     = rand_value();
        send_beat(b);
    endtask

    // call at a falling edge with valid low
    task automatic write_peephole(input bit en);
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = en;
        sb.peep_on  = en;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = 1'b0;
        src_idle              = 22;
        sink_idle             = 50;
        in_ch.valid           = 1'b0;
        in_ch.active          = 1'b0;
        in_ch.gate_input_pre  = '0;
        in_ch.gate_output_pre = '0;
        in_ch.gate_forget_pre = '0;
        in_ch.gate_cand_pre   = '0;
        in_ch.cell_prev       = '0;
        in_ch.hidden_prev     = '0;
        in_ch.peep_input      = '0;
        in_ch.peep_output     = '0;
        in_ch.peep_forget     = '0;
        repeat (11)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // peephole off after reset; weights must be ignored
        dir_beat(1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_beat(0, 1234, -1234, 77, -77, 32767, -32768, 5, 6, 7);
        dir_beat(0, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768);
        dir_beat(1, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0);
        dir_beat(1, -32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0);
        dir_beat(1, 32767, 32767, 32767, -32768, -32768, 0, 0, 0, 0);
        dir_beat(1, 0, 0, 0, 0, 32767, 0, 32767, 32767, 32767);
        dir_beat(1, 4096, -4096, 8192, -8192, -20000, 100, -32768, -32768, -32768);
        dir_beat(1, 16384, 16384, 16384, 16384, 4096, 0, 0, 0, 0);
        dir_beat(1, 16383, -16384, -16385, 16383, -4096, 0, 0, 0, 0);
        dir_beat(1, 128, -128, 1, -1, 1, -1, 0, 0, 0);
        dir_beat(1, 2048, -2048, 2047, 1024, 12345, 0, 0, 0, 0);
        in_ch.valid = 1'b0;
        write_peephole(1'b1);

        // peephole on: product and gate saturation, rounding ties
        dir_beat(1, 0, 0, 0, 0, 32767, 0, 32767, 32767, 32767);
        dir_beat(1, 0, 0, 0, 0, 32767, 0, -32768, -32768, -32768);
        dir_beat(1, 0, 0, 0, 0, -32768, 0, -32768, -32768, -32768);
        dir_beat(1, 32767, 32767, 32767, 32767, 32767, 0, 32767, 32767, 32767);
        dir_beat(1, -32768, -32768, -32768, -32768, -32768, 0, 32767, 32767, 32767);
        dir_beat(0, 100, 200, 300, 400, -5000, 6000, 32767, -32768, 32767);
        dir_beat(1, 1000, -1000, 500, 3000, 8000, 0, 2048, -2048, 4096);
        dir_beat(1, 0, 0, 0, 16384, 0, 0, 0, 32767, 0);
        dir_beat(1, -8192, 8192, 0, -16384, 16000, 0, 1, -1, 2);
        dir_beat(1, 0, 0, 0, 0, 2048, 0, 1, -1, 1);
        in_ch.valid = 1'b0;

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    src_idle  = 22;
                    sink_idle = 50;
                end
                1:
                begin
                    src_idle  = 50;
                    sink_idle = 22;
                end
                default:
                begin
                    src_idle  = 0;
                    sink_idle = 0;
                end
            endcase
            write_peephole(phase % 2 == 0);
            repeat (RAND_PER_PHASE)
            begin
                send_random();
            end
            in_ch.valid = 1'b0;
        end

        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20)
        begin
            @(posedge clk);
        end

        $display("Sent %0d active beats (%0d with peephole on) and %0d pass-through beats;",
                 sb.active_seen, sb.peep_seen, sb.inactive_seen);
        $display("checked %0d output beats across three stall mixes, %0d left unmatched.",
                 sb.results_seen, sb.expected_q.size());
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
        begin
            $display("** lstm_cell_update: PASSED **");
        end
        else
        begin
            $display("** lstm_cell_update: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/lcu_pkg.sv
rtl/lcu_in_if.sv
rtl/lcu_out_if.sv
rtl/lstm_cell_update.sv
tb/tb.sv
